// ===== src/ucd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types and constants for the undirected cycle detector.
// ----------------------------------------------------------------------------
package ucd_pkg;

    // Largest supported graph and reset value of the vertex count register
    localparam int UCD_MAX_VERTICES = 32;
    localparam logic [5:0] UCD_VCOUNT_RESET = 6'd32;

    // Fixed field widths
    localparam int UCD_VTX_W = 5;
    localparam int UCD_WGT_W = 16;

    // Weights that mean "no edge"
    localparam logic signed [UCD_WGT_W-1:0] UCD_WGT_ZERO = 16'sd0;
    localparam logic signed [UCD_WGT_W-1:0] UCD_WGT_NEG1 = -16'sd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STEP,
        ST_POP,
        ST_EMIT
    } t_state;

    // Adjacency store control from the sequencer
    typedef struct packed {
        logic                 wr;
        logic                 clr;
        logic [UCD_VTX_W-1:0] row;
        logic [UCD_VTX_W-1:0] col;
        logic                 present;
    } t_adj_ctl;

endpackage

// ===== src/undirected_cycle_detect.sv =====
// ----------------------------------------------------------------------------
// undirected_cycle_detect
// Cycle detection on an undirected graph loaded as adjacency pairs.
// ----------------------------------------------------------------------------
// Pairs load at one item per cycle; an item with last_pair set starts a
// depth-first search over vertices below vertex_count, and the block is not
// ready until the single has_cycle result is placed in the output register.
// The sequencer tests one adjacency bit per cycle in its step state, and a
// pop issues the registered stack read there and restores the frame in the
// pop state. The matrix clears in the cycle the result is issued; there is
// no clearing pass after reset. A waiting result does not block loading of
// the next graph.
module undirected_cycle_detect #(
    parameter int MAX_VERTICES = ucd_pkg::UCD_MAX_VERTICES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [5:0]                           i_cfg_vertex_count,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ucd_pkg::UCD_VTX_W-1:0]        i_row_vertex,
    input  logic [ucd_pkg::UCD_VTX_W-1:0]        i_col_vertex,
    input  logic signed [ucd_pkg::UCD_WGT_W-1:0] i_edge_weight,
    input  logic                                 i_last_pair,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_has_cycle
);
    import ucd_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int FW = 2 * VW + 1 + CW;

    t_adj_ctl                w_adj_ctl;
    logic [VW-1:0]           w_adj_vert;
    logic [MAX_VERTICES-1:0] w_adj_row;
    logic                    w_stk_wr_en;
    logic [VW-1:0]           w_stk_wr_addr;
    logic [FW-1:0]           w_stk_wr_data;
    logic                    w_stk_rd_en;
    logic [VW-1:0]           w_stk_rd_addr;
    logic [FW-1:0]           w_stk_rd_data;

    ucd_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW),
        .CW           (CW),
        .FW           (FW)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_row_vertex       (i_row_vertex),
        .i_col_vertex       (i_col_vertex),
        .i_edge_weight      (i_edge_weight),
        .i_last_pair        (i_last_pair),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_has_cycle        (o_has_cycle),
        .o_adj_ctl          (w_adj_ctl),
        .o_adj_vert         (w_adj_vert),
        .i_adj_row          (w_adj_row),
        .o_stk_wr_en        (w_stk_wr_en),
        .o_stk_wr_addr      (w_stk_wr_addr),
        .o_stk_wr_data      (w_stk_wr_data),
        .o_stk_rd_en        (w_stk_rd_en),
        .o_stk_rd_addr      (w_stk_rd_addr),
        .i_stk_rd_data      (w_stk_rd_data)
    );

    ucd_adj #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW)
    ) u_adj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_adj_ctl),
        .i_rd_vert (w_adj_vert),
        .o_rd_row  (w_adj_row)
    );

    ucd_stack #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW),
        .FW           (FW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_stk_wr_en),
        .i_wr_addr (w_stk_wr_addr),
        .i_wr_data (w_stk_wr_data),
        .i_rd_en   (w_stk_rd_en),
        .i_rd_addr (w_stk_rd_addr),
        .o_rd_data (w_stk_rd_data)
    );

`ifndef SYNTH
    // A final pair starts a search, so no item is taken in the next cycle
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_pair) |=> !o_in_ready)
        else $error("input taken right after a final pair");

    // A pair that is not final never raises a result
    a_no_result_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_last_pair && !o_out_valid) |=> !o_out_valid)
        else $error("result raised by a non-final pair");

    // Push and pop never share a cycle
    a_stack_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stk_wr_en && w_stk_rd_en))
        else $error("stack push and pop in one cycle");

    // Matrix clear only happens while no new pair is loading
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adj_ctl.clr |-> !w_adj_ctl.wr)
        else $error("matrix clear collides with a pair write");
`endif

endmodule

// ===== src/ucd_adj.sv =====
// ----------------------------------------------------------------------------
// ucd_adj
// Symmetric adjacency matrix in flip-flops: pair writes, clear, row read.
// ----------------------------------------------------------------------------
module ucd_adj #(
    parameter int MAX_VERTICES = ucd_pkg::UCD_MAX_VERTICES,
    parameter int VW           = $clog2(MAX_VERTICES)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ucd_pkg::t_adj_ctl       i_ctl,
    input  logic [VW-1:0]           i_rd_vert,
    output logic [MAX_VERTICES-1:0] o_rd_row
);
    import ucd_pkg::*;

    localparam int IW = (VW > UCD_VTX_W) ? VW : UCD_VTX_W;

    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] n_adj [MAX_VERTICES];
    logic [IW-1:0]           w_row;
    logic [IW-1:0]           w_col;

    assign w_row = IW'(i_ctl.row);
    assign w_col = IW'(i_ctl.col);

    // Clear all bits, or set or drop both mirrored bits of a pair; diagonal pairs are ignored
    always_comb begin
        for (int a = 0; a < MAX_VERTICES; a++) begin
            for (int b = 0; b < MAX_VERTICES; b++) begin
                n_adj[a][b] = r_adj[a][b];
                if (i_ctl.clr) begin
                    n_adj[a][b] = 1'b0;
                end else if (i_ctl.wr && (w_row != w_col) &&
                             (((IW'(a) == w_row) && (IW'(b) == w_col)) ||
                              ((IW'(a) == w_col) && (IW'(b) == w_row)))) begin
                    n_adj[a][b] = i_ctl.present;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < MAX_VERTICES; a++) begin
                r_adj[a] <= '0;
            end
        end else begin
            r_adj <= n_adj;
        end
    end

    assign o_rd_row = r_adj[i_rd_vert];

endmodule

// ===== src/ucd_stack.sv =====
// ----------------------------------------------------------------------------
// ucd_stack
// Frame memory for the search stack: one write port, one registered read.
// ----------------------------------------------------------------------------
module ucd_stack #(
    parameter int MAX_VERTICES = ucd_pkg::UCD_MAX_VERTICES,
    parameter int VW           = $clog2(MAX_VERTICES),
    parameter int FW           = 2 * VW + 1 + $clog2(MAX_VERTICES + 1)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [VW-1:0] i_wr_addr,
    input  logic [FW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [VW-1:0] i_rd_addr,
    output logic [FW-1:0] o_rd_data
);
    import ucd_pkg::*;

    logic [FW-1:0] r_mem [MAX_VERTICES];
    logic [FW-1:0] r_rd_data;

    // Store a pushed frame
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Fetch the frame below the top on a pop
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ucd_seq.sv =====
// ----------------------------------------------------------------------------
// ucd_seq
// Handshakes, vertex count register and the depth-first search sequencer.
// ----------------------------------------------------------------------------
module ucd_seq #(
    parameter int MAX_VERTICES = ucd_pkg::UCD_MAX_VERTICES,
    parameter int VW           = $clog2(MAX_VERTICES),
    parameter int CW           = $clog2(MAX_VERTICES + 1),
    parameter int FW           = 2 * VW + 1 + $clog2(MAX_VERTICES + 1)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [5:0]                             i_cfg_vertex_count,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [ucd_pkg::UCD_VTX_W-1:0]          i_row_vertex,
    input  logic [ucd_pkg::UCD_VTX_W-1:0]          i_col_vertex,
    input  logic signed [ucd_pkg::UCD_WGT_W-1:0]   i_edge_weight,
    input  logic                                   i_last_pair,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_has_cycle,
    output ucd_pkg::t_adj_ctl                      o_adj_ctl,
    output logic [VW-1:0]                          o_adj_vert,
    input  logic [MAX_VERTICES-1:0]                i_adj_row,
    output logic                                   o_stk_wr_en,
    output logic [VW-1:0]                          o_stk_wr_addr,
    output logic [FW-1:0]                          o_stk_wr_data,
    output logic                                   o_stk_rd_en,
    output logic [VW-1:0]                          o_stk_rd_addr,
    input  logic [FW-1:0]                          i_stk_rd_data
);
    import ucd_pkg::*;

    t_state                  r_state, n_state;
    logic [5:0]              r_vcount;
    logic [CW-1:0]           r_s, n_s;
    logic [VW-1:0]           r_vert, n_vert;
    logic [VW-1:0]           r_par, n_par;
    logic                    r_par_ok, n_par_ok;
    logic [CW-1:0]           r_next, n_next;
    logic [CW-1:0]           r_depth, n_depth;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic                    r_found, n_found;
    logic                    r_out_valid, n_out_valid;
    logic                    r_has_cycle, n_has_cycle;

    logic                    w_in_acc;
    logic [CW-1:0]           w_n;
    logic [VW-1:0]           w_i;
    logic [VW-1:0]           w_s;
    logic [CW-1:0]           w_next_inc;
    logic                    w_emit;
    logic [CW-1:0]           w_depth_m1;
    logic [CW-1:0]           w_depth_m2;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_has_cycle = r_has_cycle;

    // Clamp the vertex count to one..MAX_VERTICES
    always_comb begin
        if (r_vcount == 6'd0) begin
            w_n = CW'(1);
        end else if (int'(r_vcount) > MAX_VERTICES) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = CW'(r_vcount);
        end
    end

    assign w_i        = r_next[VW-1:0];
    assign w_s        = r_s[VW-1:0];
    assign w_next_inc = r_next + CW'(1);
    assign w_depth_m1 = r_depth - CW'(1);
    assign w_depth_m2 = r_depth - CW'(2);
    assign o_adj_vert = r_vert;

    // Next state and datapath of the search
    always_comb begin
        n_state   = r_state;
        n_s       = r_s;
        n_vert    = r_vert;
        n_par     = r_par;
        n_par_ok  = r_par_ok;
        n_next    = r_next;
        n_depth   = r_depth;
        n_visited = r_visited;
        n_found   = r_found;
        w_emit    = 1'b0;

        o_adj_ctl.wr      = w_in_acc;
        o_adj_ctl.clr     = 1'b0;
        o_adj_ctl.row     = i_row_vertex;
        o_adj_ctl.col     = i_col_vertex;
        o_adj_ctl.present = !((i_edge_weight == UCD_WGT_ZERO) ||
                              (i_edge_weight == UCD_WGT_NEG1));

        o_stk_wr_en   = 1'b0;
        o_stk_wr_addr = w_depth_m1[VW-1:0];
        o_stk_wr_data = {r_vert, r_par_ok, r_par, w_next_inc};
        o_stk_rd_en   = 1'b0;
        o_stk_rd_addr = w_depth_m2[VW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_last_pair) begin
                    n_visited = '0;
                    n_s       = '0;
                    n_depth   = '0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Find the next unvisited root
                if (r_s >= w_n) begin
                    n_found = 1'b0;
                    n_state = ST_EMIT;
                end else if (r_visited[w_s]) begin
                    n_s = r_s + CW'(1);
                end else begin
                    n_visited[w_s] = 1'b1;
                    n_vert         = w_s;
                    n_par_ok       = 1'b0;
                    n_next         = '0;
                    n_depth        = CW'(1);
                    n_state        = ST_STEP;
                end
            end
            ST_STEP: begin
                if (r_next >= w_n) begin
                    // Top frame exhausted: drop it
                    if (r_depth == CW'(1)) begin
                        n_depth = '0;
                        n_state = ST_SCAN;
                    end else begin
                        o_stk_rd_en = 1'b1;
                        n_state     = ST_POP;
                    end
                end else begin
                    n_next = w_next_inc;
                    if ((r_par_ok && (w_i == r_par)) || !i_adj_row[w_i]) begin
                        n_state = ST_STEP;
                    end else if (r_visited[w_i]) begin
                        n_found = 1'b1;
                        n_depth = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_visited[w_i] = 1'b1;
                        if (int'(r_depth) < MAX_VERTICES) begin
                            // Push the current frame, descend into the neighbor
                            o_stk_wr_en = 1'b1;
                            n_vert      = w_i;
                            n_par       = r_vert;
                            n_par_ok    = 1'b1;
                            n_next      = '0;
                            n_depth     = r_depth + CW'(1);
                        end
                    end
                end
            end
            ST_POP: begin
                {n_vert, n_par_ok, n_par, n_next} = i_stk_rd_data;
                n_depth = w_depth_m1;
                n_state = ST_STEP;
            end
            ST_EMIT: begin
                // Hand over the result once the output slot is free
                if (!r_out_valid || i_out_ready) begin
                    w_emit        = 1'b1;
                    o_adj_ctl.clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid = (r_out_valid && !i_out_ready) || w_emit;
        n_has_cycle = w_emit ? r_found : r_has_cycle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vcount    <= UCD_VCOUNT_RESET;
            r_depth     <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_vertex_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_vert      <= n_vert;
        r_par       <= n_par;
        r_par_ok    <= n_par_ok;
        r_next      <= n_next;
        r_found     <= n_found;
        r_has_cycle <= n_has_cycle;
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the undirected cycle detector.
// Streams adjacency pairs into the block, predicts each has_cycle answer
// with a union-find over the stored graph, and compares every result item
// against the oldest prediction under several idle and stall patterns and
// several vertex counts.
// ----------------------------------------------------------------------------
module tb;
    import ucd_pkg::*;

    // Worst search time for a full graph, plus some slack
    localparam int SEARCH_CYCLES = UCD_MAX_VERTICES * UCD_MAX_VERTICES
                                   + 3 * UCD_MAX_VERTICES + 16;
    localparam longint unsigned RUN_LIMIT = 64'd50_000_000;

    typedef struct {
        logic [UCD_VTX_W-1:0]        row;
        logic [UCD_VTX_W-1:0]        col;
        logic signed [UCD_WGT_W-1:0] weight;
    } t_pair;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [5:0]                  i_cfg_vertex_count;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [UCD_VTX_W-1:0]        i_row_vertex;
    logic [UCD_VTX_W-1:0]        i_col_vertex;
    logic signed [UCD_WGT_W-1:0] i_edge_weight;
    logic                        i_last_pair;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_has_cycle;

    // Predicted block state
    logic [UCD_MAX_VERTICES-1:0] adj_rows [UCD_MAX_VERTICES];
    logic [5:0]                  vcount_reg;
    logic                        expected_cycle_q [$];

    int mismatch_count;
    int sender_idle_pct;
    int recv_stall_pct;

    undirected_cycle_detect DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_row_vertex       (i_row_vertex),
        .i_col_vertex       (i_col_vertex),
        .i_edge_weight      (i_edge_weight),
        .i_last_pair        (i_last_pair),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_has_cycle        (o_has_cycle)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Effective vertex count: zero acts as one, large values saturate
    function automatic int unsigned used_vertices();
        if (vcount_reg == 6'd0) return 1;
        if (vcount_reg > UCD_MAX_VERTICES) return UCD_MAX_VERTICES;
        return 32'(vcount_reg);
    endfunction

    // An undirected graph has a cycle iff some edge joins two vertices
    // that are already connected
    function automatic logic graph_has_cycle();
        int unsigned n;
        int unsigned root [UCD_MAX_VERTICES];
        int unsigned ra;
        int unsigned rb;
        logic        found;
        n = used_vertices();
        found = 1'b0;
        for (int v = 0; v < UCD_MAX_VERTICES; v++) root[v] = v;
        for (int a = 0; a < n; a++) begin
            for (int b = a + 1; b < n; b++) begin
                if (adj_rows[a][b]) begin
                    ra = a;
                    rb = b;
                    while (root[ra] != ra) ra = root[ra];
                    while (root[rb] != rb) rb = root[rb];
                    if (ra == rb) found = 1'b1;
                    else root[ra] = rb;
                end
            end
        end
        return found;
    endfunction

    // Store one accepted pair; on the final pair predict and clear the matrix
    function automatic void predict_pair(input t_pair p, input logic last);
        logic present;
        if (p.row != p.col) begin
            present = !(p.weight == UCD_WGT_ZERO || p.weight == UCD_WGT_NEG1);
            adj_rows[p.row][p.col] = present;
            adj_rows[p.col][p.row] = present;
        end
        if (last) begin
            expected_cycle_q.push_back(graph_has_cycle());
            foreach (adj_rows[i]) adj_rows[i] = '0;
        end
    endfunction

    // Send one item, idling at random before it
    task automatic send_pair(input t_pair p, input logic last);
        @(negedge i_clk);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_row_vertex  <= p.row;
        i_col_vertex  <= p.col;
        i_edge_weight <= p.weight;
        i_last_pair   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pair(p, last);
    endtask

    task automatic send_fields(input int r, input int c, input int w, input logic last);
        t_pair p;
        p.row    = UCD_VTX_W'(r);
        p.col    = UCD_VTX_W'(c);
        p.weight = UCD_WGT_W'(w);
        send_pair(p, last);
    endtask

    // Hold the input idle until every predicted result has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_cycle_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [5:0] count);
        wait_for_results();
        repeat (SEARCH_CYCLES) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_vertex_count <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        vcount_reg = count;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [UCD_WGT_W-1:0] edge_weight_present();
        logic signed [UCD_WGT_W-1:0] w;
        case ($urandom_range(7))
            0: w = 16'sh7FFF;
            1: w = 16'sh8000;
            default: begin
                do w = UCD_WGT_W'($urandom);
                while (w == UCD_WGT_ZERO || w == UCD_WGT_NEG1);
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [UCD_WGT_W-1:0] edge_weight_absent();
        return $urandom_range(1) ? UCD_WGT_ZERO : UCD_WGT_NEG1;
    endfunction

    function automatic t_pair make_pair(input int a, input int b, input logic present);
        t_pair p;
        // Swap ends at random so reversed pairs show up too
        if ($urandom_range(1)) begin
            p.row = UCD_VTX_W'(a);
            p.col = UCD_VTX_W'(b);
        end else begin
            p.row = UCD_VTX_W'(b);
            p.col = UCD_VTX_W'(a);
        end
        p.weight = present ? edge_weight_present() : edge_weight_absent();
        return p;
    endfunction

    // Build and send one graph ending in a final pair; return items counted
    task automatic send_random_graph(output int unsigned counted);
        t_pair       graph_q [$];
        int unsigned n;
        int unsigned kind;
        int unsigned cnt;
        int unsigned a;
        int unsigned b;
        t_pair       p;
        n = used_vertices();
        kind = $urandom_range(9);
        counted = 0;
        if (kind < 6) begin
            // Spanning forest, optionally with one extra edge
            for (int v = 1; v < n; v++) begin
                if ($urandom_range(9) != 0)
                    graph_q.push_back(make_pair($urandom_range(v - 1), v, 1'b1));
            end
            if (kind >= 3 && n >= 2) begin
                a = $urandom_range(n - 1);
                do b = $urandom_range(n - 1); while (b == a);
                graph_q.push_back(make_pair(a, b, 1'b1));
            end
        end else if (kind < 9) begin
            // Random pairs inside the graph, some absent, some rewrites
            cnt = $urandom_range(n + 2);
            repeat (cnt) begin
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
                graph_q.push_back(make_pair(a, b, $urandom_range(9) < 7));
            end
        end else begin
            // Noise: any vertices, any weights
            cnt = $urandom_range(1, 6);
            repeat (cnt) begin
                p.row    = UCD_VTX_W'($urandom);
                p.col    = UCD_VTX_W'($urandom);
                p.weight = UCD_WGT_W'($urandom);
                graph_q.push_back(p);
            end
        end
        // Store an edge beyond the searched vertices now and then
        if (n < UCD_MAX_VERTICES && $urandom_range(4) == 0) begin
            a = $urandom_range(UCD_MAX_VERTICES - 1, n);
            b = $urandom_range(UCD_MAX_VERTICES - 1);
            graph_q.push_back(make_pair(a, b, 1'b1));
        end
        if (graph_q.size() == 0) begin
            a = $urandom_range(UCD_MAX_VERTICES - 1);
            graph_q.push_back(make_pair(a, a, 1'b1));
        end
        foreach (graph_q[i]) begin
            send_pair(graph_q[i], i == graph_q.size() - 1);
            if (graph_q[i].row != graph_q[i].col) counted++;
        end
    endtask

    // Small graphs at the reset vertex count
    task automatic test_basic_graphs();
        send_fields(0, 1, 1, 1'b0);
        send_fields(1, 2, 32767, 1'b0);
        send_fields(2, 0, -32768, 1'b1);
        send_fields(3, 3, 0, 1'b1);
    endtask

    // Diagonal, rewritten and reversed pairs
    task automatic test_pair_handling();
        send_fields(5, 5, 7, 1'b0);
        send_fields(5, 6, 7, 1'b1);
        send_fields(0, 1, 3, 1'b0);
        send_fields(1, 2, 3, 1'b0);
        send_fields(0, 2, 3, 1'b0);
        send_fields(2, 0, 0, 1'b1);
        send_fields(0, 1, -1, 1'b0);
        send_fields(0, 1, 4, 1'b0);
        send_fields(1, 2, -1, 1'b0);
        send_fields(2, 1, -32768, 1'b0);
        send_fields(0, 2, 1, 1'b1);
    endtask

    // Vertex count at and beyond its limits
    task automatic test_vertex_count_limits();
        write_vertex_count(6'd0);
        send_fields(0, 1, 1, 1'b0);
        send_fields(1, 2, 1, 1'b0);
        send_fields(0, 2, 1, 1'b1);
        write_vertex_count(6'd3);
        send_fields(3, 4, 1, 1'b0);
        send_fields(4, 5, 1, 1'b0);
        send_fields(3, 5, 1, 1'b0);
        send_fields(0, 1, 1, 1'b1);
        write_vertex_count(6'd63);
        send_fields(29, 30, 1, 1'b0);
        send_fields(30, 31, 1, 1'b0);
        send_fields(31, 29, 1, 1'b1);
        write_vertex_count(6'd1);
        send_fields(0, 31, 1, 1'b1);
    endtask

    // Random graphs under one idle pattern and vertex count
    task automatic test_random_traffic(input int s_pct, input int r_pct,
                                       input logic [5:0] count, input int unsigned budget);
        int unsigned sent;
        int unsigned counted;
        logic        paused;
        write_vertex_count(count);
        sender_idle_pct = s_pct;
        recv_stall_pct  = r_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget) begin
            send_random_graph(counted);
            sent += counted;
            // Drain mid-phase once so the block sees an empty pipeline
            if (!paused && sent >= budget / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
    endtask

    // Drive output ready, stalling at the current rate
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result item with the oldest prediction
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_cycle_q.size() == 0) begin
                $error("has_cycle: unexpected result, expected none, got %0b", o_has_cycle);
                mismatch_count++;
            end else begin
                want = expected_cycle_q.pop_front();
                if (o_has_cycle !== want) begin
                    $error("has_cycle: expected %0b, got %0b", want, o_has_cycle);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_vertex_count = '0;
        i_in_valid         = 1'b0;
        i_row_vertex       = '0;
        i_col_vertex       = '0;
        i_edge_weight      = '0;
        i_last_pair        = 1'b0;
        i_out_ready        = 1'b1;
        sender_idle_pct    = 0;
        recv_stall_pct     = 0;
        mismatch_count     = 0;
        vcount_reg         = UCD_VCOUNT_RESET;
        foreach (adj_rows[i]) adj_rows[i] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_graphs();
        test_pair_handling();
        test_vertex_count_limits();
        test_random_traffic(0, 0, 6'd32, 240);
        test_random_traffic(0, 0, 6'd6, 240);
        test_random_traffic(69, 0, 6'd12, 240);
        test_random_traffic(69, 0, 6'd40, 240);
        test_random_traffic(0, 69, 6'd3, 240);
        test_random_traffic(0, 69, 6'd9, 240);
        test_random_traffic(28, 28, 6'd20, 240);
        test_random_traffic(28, 28, 6'($urandom_range(2, 31)), 240);

        wait_for_results();
        repeat (SEARCH_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_cycle_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #RUN_LIMIT;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ucd_pkg.sv
src/ucd_adj.sv
src/ucd_stack.sv
src/ucd_seq.sv
src/undirected_cycle_detect.sv
bench/tb.sv
